@@ rtl/core/text_console_writer_defines.svh @@
// Assertion macros for the checker file of the console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int TAB_STEP = 4;
  localparam int PADDR_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [15:0] cell_t;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] TEXT_ATTR_RESET = 8'h0F;
  localparam logic [7:0] BLANK_ATTR_RESET = 8'h00;
  localparam cell_t INIT_CELL = {BLANK_ATTR_RESET, SPACE_CHAR};

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL = 8'd10;

  localparam logic [1:0] FUNC_PUT = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic REG_TEXT_ATTR = 1'b0;
  localparam logic REG_BLANK_ATTR = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_BLANK,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic en;
    addr_t addr;
    cell_t data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    addr_t addr;
  } ram_rd_t;

endpackage

@@ rtl/core/tcw_screen_ram.sv @@
module tcw_screen_ram
  import tcw_pkg::*;
(
  input  logic    clk,
  input  ram_wr_t wr,
  input  ram_rd_t rd,
  output cell_t   rd_data
);

  cell_t mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

@@ rtl/core/tcw_ctrl.sv @@
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_attr,
  input  logic [7:0]  blank_attr,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_data,
  output ram_wr_t     wr,
  output ram_rd_t     rd,
  input  cell_t       rd_data
);

  localparam addr_t CELL_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam addr_t SCROLL_END = ADDR_W'(LAST_ROW_BASE);
  localparam addr_t ROW_STEP = ADDR_W'(COLUMNS);

  st_t state;
  st_t state_next;

  logic [1:0]  func_q;
  logic [7:0]  char_q;
  logic [10:0] idx_q;
  logic [4:0]  row;
  logic [4:0]  row_next;
  logic [6:0]  col;
  logic [6:0]  col_next;
  addr_t       cnt;
  addr_t       copy_dst;
  logic        copy_valid;
  cell_t       data_q;

  addr_t pos;
  logic  last_row;
  logic  tab_wrap;
  logic  col_end;
  logic  origin;
  logic  idx_ok;
  logic  out_free;

  assign pos = ADDR_W'(32'(row) * COLUMNS + 32'(col));
  assign last_row = (32'(row) + 1) >= ROWS;
  assign tab_wrap = (32'(col) + TAB_STEP) >= COLUMNS;
  assign col_end = (32'(col) + 1) >= COLUMNS;
  assign origin = (row == 5'd0) && (col == 7'd0);
  assign idx_ok = 32'(idx_q) < CELL_COUNT;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (cnt == CELL_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        case (func_q)
          FUNC_PUT: begin
            case (char_q)
              CH_NUL: state_next = ST_DONE;
              CH_NL: if (last_row) state_next = ST_SCROLL;
              CH_TAB: if (tab_wrap && last_row) state_next = ST_SCROLL;
              CH_BS: if (!origin) state_next = ST_BLANK;
              default: if (col_end && last_row) state_next = ST_SCROLL;
            endcase
          end
          FUNC_CLEAR: state_next = ST_FILL;
          FUNC_READ: if (idx_ok) state_next = ST_READ;
          default: state_next = ST_DONE;
        endcase
      end
      ST_READ: state_next = ST_DONE;
      ST_BLANK: state_next = ST_DONE;
      ST_SCROLL: begin
        if (cnt == SCROLL_END) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (cnt == CELL_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    wr = '0;
    rd = '0;
    case (state)
      ST_INIT: begin
        wr.en = 1'b1;
        wr.addr = cnt;
        wr.data = INIT_CELL;
      end
      ST_EXEC: begin
        if (func_q == FUNC_PUT && char_q != CH_NUL && char_q != CH_NL &&
            char_q != CH_TAB && char_q != CH_BS) begin
          wr.en = 1'b1;
          wr.addr = pos;
          wr.data = {text_attr, char_q};
        end
        if (func_q == FUNC_READ && idx_ok) begin
          rd.en = 1'b1;
          rd.addr = ADDR_W'(idx_q);
        end
      end
      ST_BLANK: begin
        wr.en = 1'b1;
        wr.addr = pos;
        wr.data = {text_attr, SPACE_CHAR};
      end
      ST_SCROLL: begin
        rd.en = (cnt != SCROLL_END);
        rd.addr = cnt + ROW_STEP;
        wr.en = copy_valid;
        wr.addr = copy_dst;
        wr.data = rd_data;
      end
      ST_FILL: begin
        wr.en = 1'b1;
        wr.addr = cnt;
        wr.data = {blank_attr, SPACE_CHAR};
      end
      default: begin
        wr = '0;
        rd = '0;
      end
    endcase
  end

  always_comb begin
    row_next = row;
    col_next = col;
    case (func_q)
      FUNC_PUT: begin
        case (char_q)
          CH_NUL: row_next = row;
          CH_NL: begin
            col_next = 7'd0;
            row_next = last_row ? row : row + 5'd1;
          end
          CH_TAB: begin
            if (tab_wrap) begin
              col_next = 7'd0;
              row_next = last_row ? row : row + 5'd1;
            end else begin
              col_next = 7'(32'(col) + TAB_STEP);
            end
          end
          CH_BS: begin
            if (col != 7'd0) begin
              col_next = col - 7'd1;
            end else if (row != 5'd0) begin
              row_next = row - 5'd1;
              col_next = 7'(COLUMNS - 1);
            end
          end
          default: begin
            if (col_end) begin
              col_next = 7'd0;
              row_next = last_row ? row : row + 5'd1;
            end else begin
              col_next = col + 7'd1;
            end
          end
        endcase
      end
      FUNC_CLEAR: begin
        row_next = 5'd0;
        col_next = 7'd0;
      end
      default: row_next = row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      row <= 5'd0;
      col <= 7'd0;
      cnt <= '0;
      copy_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_INIT: begin
          cnt <= (cnt == CELL_LAST) ? '0 : cnt + addr_t'(1);
        end
        ST_EXEC: begin
          row <= row_next;
          col <= col_next;
          cnt <= '0;
          copy_valid <= 1'b0;
        end
        ST_SCROLL: begin
          if (cnt != SCROLL_END) begin
            copy_dst <= cnt;
            copy_valid <= 1'b1;
            cnt <= cnt + addr_t'(1);
          end else begin
            copy_valid <= 1'b0;
          end
        end
        ST_FILL: begin
          if (cnt != CELL_LAST) cnt <= cnt + addr_t'(1);
        end
        default: cnt <= cnt;
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      func_q <= func;
      char_q <= char_code;
      idx_q <= cell_index;
      data_q <= '0;
    end else if (state == ST_READ) begin
      data_q <= rd_data;
    end
    if (state == ST_DONE && out_free) begin
      cursor_row <= row;
      cursor_col <= col;
      cursor_position <= 11'(pos);
      cell_data <= data_q;
    end
  end

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer: a character-cell screen store with a cursor.
// Items enter on in_valid/in_stall with func, char_code and cell_index and
// leave on out_valid/out_stall with the cursor after the operation and, for
// a read, the cell as attribute:character. Every item gives one result.
// An item is taken only while in_stall is low; one item is worked at a time.
// NUL, an unused func, a read outside the screen, a newline above the bottom
// row, a backspace at the origin and a character or tab that does not scroll
// go from ST_EXEC straight to ST_DONE; other backspaces and a cell read pass
// through ST_BLANK or ST_READ first. A new item is taken only back in idle.
// A newline on the bottom row scrolls: one store read and one store write a
// cycle move (ROWS-1)*COLUMNS cells, then COLUMNS cells are blanked before
// out_valid. Clear blanks every cell one per cycle. The single-port-pair
// screen memory sets these walks.
// After reset the store is cleared to blank cells, one per cycle, while
// in_stall stays high; register writes go on.
// The result sits in an output register: a stalled receiver holds it, and
// the next item may be accepted meanwhile, finishing once the register frees.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [7:0]         char_code,
  input  logic [10:0]        cell_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         cursor_row,
  output logic [6:0]         cursor_col,
  output logic [10:0]        cursor_position,
  output logic [15:0]        cell_data
);

  logic [7:0] text_attr;
  logic [7:0] blank_attr;
  ram_wr_t    wr;
  ram_rd_t    rd;
  cell_t      rd_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= TEXT_ATTR_RESET;
      blank_attr <= BLANK_ATTR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TEXT_ATTR: text_attr <= pwdata[7:0];
        REG_BLANK_ATTR: blank_attr <= pwdata[7:0];
        default: text_attr <= text_attr;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TEXT_ATTR: prdata = {24'd0, text_attr};
      REG_BLANK_ATTR: prdata = {24'd0, blank_attr};
      default: prdata = '0;
    endcase
  end

  tcw_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .text_attr       (text_attr),
    .blank_attr      (blank_attr),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .wr              (wr),
    .rd              (rd),
    .rd_data         (rd_data)
  );

  tcw_screen_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

endmodule

@@ rtl/core/tcw_checker.sv @@
`include "text_console_writer_defines.svh"

module tcw_checker
  import tcw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  cursor_row,
  input logic [6:0]  cursor_col,
  input logic [10:0] cursor_position
);

  `TCW_ASSERT_ALWAYS(a_reset_stalls_input, rst |=> in_stall, "input not stalled after reset")
  `TCW_ASSERT(a_row_range, out_valid |-> (32'(cursor_row) < ROWS), "cursor row out of range")
  `TCW_ASSERT(a_col_range, out_valid |-> (32'(cursor_col) < COLUMNS), "cursor column out of range")
  `TCW_ASSERT(a_position, out_valid |-> (cursor_position == 11'(32'(cursor_row) * COLUMNS + 32'(cursor_col))), "cursor position mismatch")
  `TCW_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(cursor_position)), "stalled result changed")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

@@ tb/text_console_writer_test.sv @@
module text_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] code;
    logic [10:0] index;
  } console_item_t;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [10:0] position;
    cell_t data;
  } cursor_report_t;

  typedef enum {FREE_FLOW, RANDOM_STALL, PATTERN_STALL} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = '0;
  logic [7:0] char_code = '0;
  logic [10:0] cell_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic [10:0] cursor_position;
  logic [15:0] cell_data;

  text_console_writer uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .char_code(char_code),
    .cell_index(cell_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .cursor_position(cursor_position),
    .cell_data(cell_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the screen, the cursor and the attribute registers.
  cell_t screen [CELL_COUNT];
  int cur_row = 0;
  int cur_col = 0;
  logic [7:0] text_attr = TEXT_ATTR_RESET;
  logic [7:0] blank_attr = BLANK_ATTR_RESET;

  console_item_t items_to_send [$];
  cursor_report_t reports_due [$];
  logic in_taken = 1'b0;

  int fail_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int reads_done = 0;
  int scrolls_done = 0;
  int clears_done = 0;
  int settings_used = 0;
  int holds_done = 0;

  function automatic void blank_screen();
    int i;
    for (i = 0; i < CELL_COUNT; i++) screen[i] = {blank_attr, SPACE_CHAR};
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic void new_line();
    int i;
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      for (i = 0; i < LAST_ROW_BASE; i++) screen[i] = screen[i + COLUMNS];
      for (i = LAST_ROW_BASE; i < CELL_COUNT; i++) screen[i] = {blank_attr, SPACE_CHAR};
      cur_row = ROWS - 1;
      scrolls_done++;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic cursor_report_t apply_item(console_item_t it);
    cursor_report_t r;
    r = '0;
    if (it.func == FUNC_PUT) begin
      case (it.code)
        CH_NUL: ;
        CH_NL: new_line();
        CH_TAB: begin
          if (cur_col + TAB_STEP >= COLUMNS) new_line();
          else cur_col += TAB_STEP;
        end
        CH_BS: begin
          if (cur_row != 0 || cur_col != 0) begin
            if (cur_col > 0) begin
              cur_col--;
            end else begin
              cur_row--;
              cur_col = COLUMNS - 1;
            end
            screen[cur_row * COLUMNS + cur_col] = {text_attr, SPACE_CHAR};
          end
        end
        default: begin
          screen[cur_row * COLUMNS + cur_col] = {text_attr, it.code};
          cur_col++;
          if (cur_col >= COLUMNS) new_line();
        end
      endcase
    end else if (it.func == FUNC_CLEAR) begin
      blank_screen();
      clears_done++;
    end else if (it.func == FUNC_READ) begin
      reads_done++;
      if (it.index < CELL_COUNT) r.data = screen[it.index];
    end
    r.row = 5'(cur_row);
    r.col = 7'(cur_col);
    r.position = 11'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < 10) $display("%t: %s", $realtime, msg);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    cursor_report_t want;
    cursor_report_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got = {cursor_row, cursor_col, cursor_position, cell_data};
        results_seen++;
        if (reports_due.size() == 0) begin
          note_failure($sformatf("unexpected result: row %0d col %0d pos %0d cell %h",
                                 got.row, got.col, got.position, got.data));
        end else begin
          want = reports_due.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.position !== want.position || got.data !== want.data) begin
            note_failure($sformatf(
                {"result %0d: expected row %0d col %0d pos %0d cell %h, ",
                 "got row %0d col %0d pos %0d cell %h"},
                results_seen, want.row, want.col, want.position, want.data,
                got.row, got.col, got.position, got.data));
          end
        end
      end
      if (in_valid && !in_stall) begin
        reports_due.push_back(apply_item({func, char_code, cell_index}));
        items_sent++;
      end
    end
  end

  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) void'(items_to_send.pop_front());
      if (in_valid && !in_taken) begin
        // The offered item has not been taken yet, so it stays as it is.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        in_valid <= 1'b1;
        func <= items_to_send[0].func;
        char_code <= items_to_send[0].code;
        cell_index <= items_to_send[0].index;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(8, 30);
          else gap_left = $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  stall_mode_t stall_mode = FREE_FLOW;
  int stall_mode_left = 0;
  logic [7:0] stall_pattern = 8'h01;
  int hold_left = 0;

  // The receiver twice holds off for a long stretch so that the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && results_seen >= 400 + 900 * holds_done) begin
        hold_left = 600;
        holds_done++;
      end
      if (stall_mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_mode_left = $urandom_range(20, 200);
        stall_pattern = 8'($urandom_range(1, 255));
      end else begin
        stall_mode_left--;
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          FREE_FLOW: out_stall <= 1'b0;
          RANDOM_STALL: out_stall <= ($urandom_range(0, 99) < 40);
          default: out_stall <= stall_pattern[0];
        endcase
      end
    end
  end

  task automatic write_attr(logic reg_sel, logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_TEXT_ATTR) text_attr = value;
    else blank_attr = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic queue_item(logic [1:0] f, logic [7:0] c, logic [10:0] ix);
    items_to_send.push_back({f, c, ix});
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (items_to_send.size() != 0 || reports_due.size() != 0 || in_valid);
  endtask

  // Mostly runs of text, line breaks, tabs and backspaces, with reads aimed at
  // the rows where text tends to sit; NUL and the unused operation are noise.
  task automatic queue_random_text(int n);
    int counted;
    int pick;
    int len;
    int k;
    logic [7:0] c;
    logic [10:0] ix;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 44) begin
        len = (pick < 40) ? $urandom_range(1, 30) : $urandom_range(60, 100);
        for (k = 0; k < len; k++) begin
          if (pick < 40 && $urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
          else c = 8'($urandom_range(8'h20, 8'h7E));
          queue_item(FUNC_PUT, c, 11'($urandom));
          if (c != CH_NUL) counted++;
        end
      end else if (pick < 59) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) queue_item(FUNC_PUT, CH_NL, 11'($urandom));
        counted += len;
      end else if (pick < 66) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) queue_item(FUNC_PUT, CH_TAB, 11'($urandom));
        counted += len;
      end else if (pick < 74) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) queue_item(FUNC_PUT, CH_BS, 11'($urandom));
        counted += len;
      end else if (pick < 90) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: ix = 11'($urandom_range(LAST_ROW_BASE - 2 * COLUMNS, CELL_COUNT - 1));
            4, 5, 6: ix = 11'($urandom_range(0, 3 * COLUMNS - 1));
            7, 8: ix = 11'($urandom_range(0, CELL_COUNT - 1));
            default: ix = 11'($urandom_range(CELL_COUNT, 2047));
          endcase
          queue_item(FUNC_READ, 8'($urandom), ix);
        end
        counted += len;
      end else if (pick < 91) begin
        queue_item(FUNC_CLEAR, 8'($urandom), 11'($urandom));
        counted++;
      end else if (pick < 94) begin
        queue_item(FUNC_UNUSED, 8'($urandom), 11'($urandom));
      end else begin
        queue_item(FUNC_PUT, CH_NUL, 11'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] text_set [4];
    logic [7:0] blank_set [4];
    int phase;
    blank_screen();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (in_stall);

    write_attr(REG_TEXT_ATTR, 8'h4F);
    write_attr(REG_BLANK_ATTR, 8'hA5);
    settings_used++;

    queue_item(FUNC_READ, 8'h00, 11'd0);
    queue_item(FUNC_PUT, 8'h41, 11'h7FF);
    queue_item(FUNC_PUT, 8'hFF, 11'd0);
    queue_item(FUNC_PUT, 8'h01, 11'd0);
    queue_item(FUNC_PUT, CH_NUL, 11'd0);
    queue_item(FUNC_PUT, CH_TAB, 11'd0);
    queue_item(FUNC_PUT, CH_BS, 11'd0);
    queue_item(FUNC_READ, 8'h00, 11'd6);
    queue_item(FUNC_READ, 8'hFF, 11'd1);
    queue_item(FUNC_PUT, CH_NL, 11'd0);
    // Backspace at column zero lands on the last column of the row above,
    // from where a tab and a plain character both start a new line.
    queue_item(FUNC_PUT, CH_BS, 11'd0);
    queue_item(FUNC_PUT, CH_TAB, 11'd0);
    queue_item(FUNC_PUT, CH_BS, 11'd0);
    queue_item(FUNC_PUT, 8'h7E, 11'd0);
    queue_item(FUNC_READ, 8'h00, 11'd79);
    queue_item(FUNC_READ, 8'h00, 11'(CELL_COUNT - 1));
    queue_item(FUNC_READ, 8'h00, 11'(CELL_COUNT));
    queue_item(FUNC_READ, 8'h00, 11'h7FF);
    queue_item(FUNC_UNUSED, 8'hFF, 11'h7FF);
    queue_item(FUNC_CLEAR, 8'hFF, 11'h7FF);
    queue_item(FUNC_PUT, CH_BS, 11'd0);
    queue_item(FUNC_READ, 8'h00, 11'd1);
    queue_item(FUNC_READ, 8'h00, 11'd0);
    wait_quiet();

    text_set = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), TEXT_ATTR_RESET};
    blank_set = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), BLANK_ATTR_RESET};
    for (phase = 0; phase < 4; phase++) begin
      write_attr(REG_TEXT_ATTR, text_set[phase]);
      write_attr(REG_BLANK_ATTR, blank_set[phase]);
      settings_used++;
      queue_random_text(488);
      wait_quiet();
    end

    repeat (20) @(negedge clk);
    if (reports_due.size() != 0) note_failure("results still outstanding at the end of the run");
    $display("Checked %0d results from %0d items: %0d cell reads, %0d scrolls, %0d clears.",
             results_seen, items_sent, reads_done, scrolls_done, clears_done);
    $display("Ran under %0d attribute settings with %0d long receiver hold-offs; %0d failures.",
             settings_used, holds_done, fail_count);
    if (fail_count == 0) begin
      $display("[text_console_writer] OK");
    end else begin
      $display("[text_console_writer] ERROR");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("[text_console_writer] ERROR");
    $finish;
  end

endmodule
